/* src/fdp_pkg.sv */
// Shared types, constants and dither helpers for the framebuffer dither/pack core.
// No dependencies; used by every module in src.
package fdp_pkg;

  localparam int unsigned COORD_LIMIT = 4096;
  localparam int unsigned NUM_CH      = 3;

  // dither mask constants
  localparam logic [7:0] MASK_ROW_MUL = 8'd236;
  localparam logic [7:0] MASK_CH_STEP = 8'd67;
  localparam logic [7:0] MASK_MUL     = 8'd119;

  typedef enum logic [2:0] {
    FMT_BGRA32 = 3'd0,
    FMT_RGB24  = 3'd1,
    FMT_RGB565 = 3'd2,
    FMT_RGB555 = 3'd3,
    FMT_IDX8   = 3'd4
  } fmt_e;

  // quantizer level count per channel: 32, 64, 6 or 7 levels
  typedef enum logic [1:0] {
    LVL_32,
    LVL_64,
    LVL_6,
    LVL_7
  } lvl_e;

  typedef struct packed {
    logic [2:0] fmt;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  function automatic lvl_e chan_lvl(logic [2:0] fmt, logic [1:0] ch);
    lvl_e l;
    l = LVL_32;
    case (fmt)
      FMT_RGB565: l = (ch == 2'd1) ? LVL_64 : LVL_32;
      FMT_IDX8:   l = (ch == 2'd1) ? LVL_7 : LVL_6;
      default:    l = LVL_32;
    endcase
    return l;
  endfunction

  function automatic logic [5:0] lvl_steps(lvl_e l);
    logic [5:0] s;
    s = 6'd31;
    case (l)
      LVL_32:  s = 6'd31;
      LVL_64:  s = 6'd63;
      LVL_6:   s = 6'd5;
      LVL_7:   s = 6'd6;
      default: s = 6'd31;
    endcase
    return s;
  endfunction

  // floor(q / steps) for 8-bit q, by reciprocal multiply (exact over 0..255)
  function automatic logic [5:0] off_div(logic [7:0] q, lvl_e l);
    logic [17:0] p;
    logic [5:0]  r;
    p = '0;
    r = '0;
    case (l)
      LVL_32: begin
        p = 18'(q) * 18'd265;
        r = 6'(p >> 13);
      end
      LVL_64: begin
        p = 18'(q) * 18'd261;
        r = 6'(p >> 14);
      end
      LVL_6: begin
        p = 18'(q) * 18'd410;
        r = 6'(p >> 11);
      end
      LVL_7: begin
        p = 18'(q) * 18'd342;
        r = 6'(p >> 11);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/fdp_mask.sv */
// Ordered-dither mask generator: two register stages, one mask byte per channel.
// Depends on fdp_pkg.
module fdp_mask (
  input  logic                                    clk_i,
  input  logic [7:0]                              column_i,
  input  logic [7:0]                              row_i,
  output logic [fdp_pkg::NUM_CH-1:0][7:0]         mask_o
);

  localparam logic [fdp_pkg::NUM_CH-1:0][7:0] ChOff = {
    8'(2 * fdp_pkg::MASK_CH_STEP), fdp_pkg::MASK_CH_STEP, 8'd0
  };

  logic [7:0]                      base_d, base_q;
  logic [fdp_pkg::NUM_CH-1:0][7:0] mask_d, mask_q;
  logic [15:0]                     row_prod;

  always_comb begin
    row_prod = 16'(row_i) * 16'(fdp_pkg::MASK_ROW_MUL);
    base_d   = column_i + row_prod[7:0];
  end

  always_comb begin
    logic [7:0]  sum;
    logic [15:0] prod;
    sum  = '0;
    prod = '0;
    for (int c = 0; c < fdp_pkg::NUM_CH; c++) begin
      sum       = base_q + ChOff[c];
      prod      = 16'(sum) * 16'(fdp_pkg::MASK_MUL);
      mask_d[c] = prod[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    mask_q <= mask_d;
  end

  assign mask_o = mask_q;

endmodule

/* src/fdp_quant.sv */
// One channel's dither quantizer: offset, saturate and scale, divide by 255.
// Three register stages. Depends on fdp_pkg.
module fdp_quant (
  input  logic                clk_i,
  input  logic [7:0]          mask_i,
  input  logic [7:0]          value_i,
  input  fdp_pkg::lvl_e       lvl_i,
  output logic [5:0]          quant_o
);

  logic [7:0]    off_base;
  logic [5:0]    off_d, off_q;
  logic [7:0]    val_q;
  fdp_pkg::lvl_e lvl_q;
  logic [8:0]    sum;
  logic [7:0]    sat;
  logic [13:0]   scaled_d, scaled_q;
  logic [14:0]   div_t;
  logic [5:0]    quant_d, quant_q;

  // floor(m*255/256) is m-1 for m > 0
  always_comb begin
    off_base = (mask_i == 8'd0) ? 8'd0 : mask_i - 8'd1;
    off_d    = fdp_pkg::off_div(off_base, lvl_i);
  end

  always_comb begin
    sum      = {1'b0, val_q} + {3'b0, off_q};
    sat      = sum[8] ? 8'hff : sum[7:0];
    scaled_d = 14'(sat) * 14'(fdp_pkg::lvl_steps(lvl_q));
  end

  // exact floor(n/255) for n < 65535
  always_comb begin
    div_t   = 15'(scaled_q) + 15'(scaled_q >> 8) + 15'd1;
    quant_d = 6'(div_t >> 8);
  end

  always_ff @(posedge clk_i) begin
    off_q    <= off_d;
    val_q    <= value_i;
    lvl_q    <= lvl_i;
    scaled_q <= scaled_d;
    quant_q  <= quant_d;
  end

  assign quant_o = quant_q;

endmodule

/* src/fdp_pack.sv */
// Output stage: packs the pixel into framebuffer bytes for the latched format.
// Depends on fdp_pkg.
module fdp_pack (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  fdp_pkg::pix_t                    pix_i,
  input  logic [fdp_pkg::NUM_CH-1:0][5:0]  quant_i,
  output logic                             done_o,
  output logic [31:0]                      packed_bytes_o,
  output logic [2:0]                       byte_count_o
);

  localparam logic [2:0] Bytes32 = 3'd4;
  localparam logic [2:0] Bytes24 = 3'd3;
  localparam logic [2:0] Bytes16 = 3'd2;
  localparam logic [2:0] Bytes8  = 3'd1;
  localparam logic [2:0] BytesNo = 3'd0;

  logic        done_q;
  logic [31:0] packed_d, packed_q;
  logic [2:0]  count_d, count_q;
  logic [7:0]  idx;

  always_comb begin
    idx = 8'(quant_i[0][2:0]) * 8'd42 + 8'(quant_i[1][2:0]) * 8'd6 + 8'(quant_i[2][2:0]);
  end

  always_comb begin
    packed_d = '0;
    count_d  = BytesNo;
    case (pix_i.fmt)
      fdp_pkg::FMT_BGRA32: begin
        packed_d = {pix_i.alpha, pix_i.red, pix_i.green, pix_i.blue};
        count_d  = Bytes32;
      end
      fdp_pkg::FMT_RGB24: begin
        packed_d = {8'd0, pix_i.blue, pix_i.green, pix_i.red};
        count_d  = Bytes24;
      end
      fdp_pkg::FMT_RGB565: begin
        packed_d = {16'd0, quant_i[0][4:0], quant_i[1][5:0], quant_i[2][4:0]};
        count_d  = Bytes16;
      end
      fdp_pkg::FMT_RGB555: begin
        packed_d = {17'd0, quant_i[0][4:0], quant_i[1][4:0], quant_i[2][4:0]};
        count_d  = Bytes16;
      end
      fdp_pkg::FMT_IDX8: begin
        packed_d = {24'd0, idx};
        count_d  = Bytes8;
      end
      default: begin
        packed_d = '0;
        count_d  = BytesNo;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    packed_q <= packed_d;
    count_q  <= count_d;
  end

  assign done_o         = done_q;
  assign packed_bytes_o = packed_q;
  assign byte_count_o   = count_q;

endmodule

/* src/framebuffer_dither_pack_core.sv */
// Framebuffer dither/pack core: RGBA pixel in, framebuffer bytes out.
// Depends on fdp_pkg, fdp_mask, fdp_quant and fdp_pack.
//
// Usage:
//   Input: drive red/green/blue/alpha/column/row with start_i high; a pixel
//   transfer happens at every rising edge with start_i high and busy_o low.
//   busy_o is always low: one pixel per clock is taken, back to back.
//   Output: done_o is high for exactly one cycle per pixel, with
//   packed_bytes_o (first byte in bits 7:0) and byte_count_o valid in that
//   cycle. The receiver cannot stall the output; results come in input order.
//   Throughput: 1 pixel per cycle, set by the six-stage pipeline
//   (mask base, mask, dither offset, saturate/scale, /255, pack).
//   Configuration: cfg_we_i writes pixel_format from cfg_wdata_i; write it
//   only while the pipeline is empty. Format codes 5..7 give zero bytes.
//   Reset: rst_ni (async, active low) clears the pipeline valid bits and sets
//   the format to 32bpp BGRA. No clearing pass is needed.
module framebuffer_dither_pack_core #(
  parameter int unsigned CoordLimit = fdp_pkg::COORD_LIMIT,
  localparam int unsigned CoordW    = $clog2(CoordLimit)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic [7:0]        alpha_i,
  input  logic [CoordW-1:0] column_i,
  input  logic [CoordW-1:0] row_i,
  output logic              done_o,
  output logic [31:0]       packed_bytes_o,
  output logic [2:0]        byte_count_o
);

  localparam int unsigned Stages = 5;

  logic [2:0]                      fmt_q;
  logic [Stages-1:0]               vld_q;
  fdp_pkg::pix_t                   side_q [Stages];
  fdp_pkg::pix_t                   side_d;
  logic                            accept;
  logic [fdp_pkg::NUM_CH-1:0][7:0] mask;
  logic [fdp_pkg::NUM_CH-1:0][7:0] chan_val;
  logic [fdp_pkg::NUM_CH-1:0][5:0] quant;
  fdp_pkg::lvl_e                   lvl [fdp_pkg::NUM_CH];

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_comb begin
    side_d.fmt   = fmt_q;
    side_d.red   = red_i;
    side_d.green = green_i;
    side_d.blue  = blue_i;
    side_d.alpha = alpha_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= fdp_pkg::FMT_BGRA32;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      vld_q <= {vld_q[Stages-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < Stages; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  fdp_mask u_mask (
    .clk_i    (clk_i),
    .column_i (column_i[7:0]),
    .row_i    (row_i[7:0]),
    .mask_o   (mask)
  );

  assign chan_val = {side_q[1].blue, side_q[1].green, side_q[1].red};

  for (genvar c = 0; c < fdp_pkg::NUM_CH; c++) begin : g_chan
    assign lvl[c] = fdp_pkg::chan_lvl(side_q[1].fmt, 2'(c));

    fdp_quant u_quant (
      .clk_i   (clk_i),
      .mask_i  (mask[c]),
      .value_i (chan_val[c]),
      .lvl_i   (lvl[c]),
      .quant_o (quant[c])
    );
  end

  fdp_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (vld_q[Stages-1]),
    .pix_i          (side_q[Stages-1]),
    .quant_i        (quant),
    .done_o         (done_o),
    .packed_bytes_o (packed_bytes_o),
    .byte_count_o   (byte_count_o)
  );

endmodule
